// ----- src/psc_pkg.sv -----
// Shared types and constants for the peptide sequence coverage core.
package psc_pkg;

    localparam int MAX_SEQUENCE = 4096;

    typedef enum logic [1:0] {
        ACT_SEQ   = 2'd0,
        ACT_PEP   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_PEP_LONG = 2'd1,
        ST_SEQ_OVF  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] residue;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [12:0] covered_count;
        logic [12:0] sequence_length;
        logic [16:0] coverage_fraction;
        logic [1:0]  status;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CMP_ADDR,
        S_CMP_WAIT,
        S_CMP_TEST,
        S_MARK_ADDR,
        S_MARK_WAIT,
        S_MARK_TEST,
        S_DIV,
        S_OUT
    } state_t;

endpackage

// ----- src/psc_divider.sv -----
// Restoring divider, one quotient bit per cycle.
module psc_divider #(
    parameter int NW = 13,
    parameter int QW = 17
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [NW-1:0] denom,
    output logic          done,
    output logic [QW-1:0] quot
);
    localparam int DW = NW + 16;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] dividend_reg, dividend_next;
    logic [NW:0]   rem_reg, rem_next;
    logic [DW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW:0]   trial;
    logic [NW+1:0] diff;

    always_comb begin
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        trial         = {rem_reg[NW-1:0], dividend_reg[DW-1]};
        diff          = {1'b0, trial} - {2'b00, denom};
        if (start) begin
            dividend_next = {numer, 16'd0};
            rem_next      = '0;
            q_next        = '0;
            cnt_next      = CW'(DW);
            busy_next     = 1'b1;
        end else if (busy_reg) begin
            dividend_next = {dividend_reg[DW-2:0], 1'b0};
            if (!diff[NW+1]) begin
                rem_next = diff[NW:0];
                q_next   = {q_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next   = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        cnt_reg      <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg[QW-1:0];
endmodule

// ----- src/peptide_sequence_coverage_core.sv -----
// Top level of the peptide sequence coverage core.
// Sequence and peptide residues are taken one per cycle while the core is
// idle. A valid peptide's last residue starts a search that steps one
// comparison at a time through the single sequence memory port and then
// marks the covered entries of each hit. A query on a non-empty sequence
// runs a bit-serial divider. After reset, and for a new
// sequence after a finished one, the coverage memory is cleared one entry
// per cycle, with the input not ready. The result register holds a query
// answer until it is taken; no input is taken while it waits.
module peptide_sequence_coverage_core #(
    parameter int MAX_PEPTIDE  = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  psc_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output psc_pkg::out_item_t  m_data
);
    import psc_pkg::*;

    localparam int SA = $clog2(MAX_SEQUENCE);
    localparam int SL = $clog2(MAX_SEQUENCE + 1);
    localparam int PA = $clog2(MAX_PEPTIDE);
    localparam int PL = $clog2(MAX_PEPTIDE + 1);

    logic [7:0] seq_mem [MAX_SEQUENCE];
    logic       cov_mem [MAX_SEQUENCE];
    logic [7:0] pep_mem [MAX_PEPTIDE];

    state_t      state_reg, state_next;
    logic [SL-1:0] len_reg, len_next;
    logic [PL-1:0] plen_reg, plen_next;
    logic [12:0] tot_reg, tot_next;
    logic        done_reg, done_next;
    logic [1:0]  err_reg, err_next;
    logic        polong_reg, polong_next;
    logic [SL-1:0] start_reg, start_next;
    logic [PL-1:0] j_reg, j_next;
    logic        pend_reg, pend_next;
    logic        load_reg, load_next;
    logic [7:0]  res_reg, res_next;
    logic        ov_reg, ov_next;
    out_item_t   out_reg, out_next;

    logic          seq_we, cov_we, pep_we;
    logic [SA-1:0] seq_wa, cov_a, seq_ra;
    logic [7:0]    seq_wd;
    logic          cov_wd;
    logic [PA-1:0] pep_wa, pep_ra;
    logic [7:0]    seq_rd_reg, pep_rd_reg;
    logic          cov_rd_reg;
    logic          div_start, div_done;
    logic [16:0]   div_q;
    logic          acc;
    logic [SL-1:0] pos;

    assign acc = s_valid && s_ready;
    assign pos = start_reg + SL'(j_reg);

    always_ff @(posedge aclk) begin
        if (seq_we) seq_mem[seq_wa] <= seq_wd;
        if (pep_we) pep_mem[pep_wa] <= s_data.residue;
        if (cov_we) cov_mem[cov_a] <= cov_wd;
        seq_rd_reg <= seq_mem[seq_ra];
        pep_rd_reg <= pep_mem[pep_ra];
        cov_rd_reg <= cov_mem[cov_a];
    end

    psc_divider #(.NW(13), .QW(17)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (tot_reg),
        .denom   (13'(len_reg)),
        .done    (div_done),
        .quot    (div_q)
    );

    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        plen_next   = plen_reg;
        tot_next    = tot_reg;
        done_next   = done_reg;
        err_next    = err_reg;
        polong_next = polong_reg;
        start_next  = start_reg;
        j_next      = j_reg;
        pend_next   = pend_reg;
        load_next   = load_reg;
        res_next    = res_reg;
        ov_next     = ov_reg;
        out_next    = out_reg;
        seq_we      = 1'b0;
        seq_wa      = len_reg[SA-1:0];
        seq_wd      = s_data.residue;
        pep_we      = 1'b0;
        pep_wa      = plen_reg[PA-1:0];
        cov_we      = 1'b0;
        cov_wd      = 1'b0;
        cov_a       = pos[SA-1:0];
        seq_ra      = pos[SA-1:0];
        pep_ra      = j_reg[PA-1:0];
        div_start   = 1'b0;
        s_ready     = (state_reg == S_IDLE) && !ov_reg;
        if (m_valid && m_ready) ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    unique case (action_t'(s_data.action))
                        ACT_SEQ: begin
                            if (done_reg) begin
                                pend_next  = s_data.last;
                                load_next  = 1'b1;
                                res_next   = s_data.residue;
                                start_next = '0;
                                state_next = S_CLEAR;
                            end else if (len_reg < SL'(MAX_SEQUENCE)) begin
                                seq_we   = 1'b1;
                                len_next = len_reg + 1'b1;
                                if (s_data.last) done_next = 1'b1;
                            end else begin
                                err_next[1] = 1'b1;
                                if (s_data.last) done_next = 1'b1;
                            end
                        end
                        ACT_PEP: begin
                            if (plen_reg < PL'(MAX_PEPTIDE)) begin
                                pep_we    = 1'b1;
                                plen_next = plen_reg + 1'b1;
                            end else begin
                                polong_next = 1'b1;
                            end
                            if (s_data.last) begin
                                if (polong_reg || plen_reg == PL'(MAX_PEPTIDE)) begin
                                    err_next[0] = 1'b1;
                                    plen_next   = '0;
                                    polong_next = 1'b0;
                                end else if (SL'(plen_reg) + 1'b1 > len_reg) begin
                                    plen_next = '0;
                                end else begin
                                    start_next = '0;
                                    j_next     = '0;
                                    state_next = S_CMP_ADDR;
                                end
                            end
                        end
                        ACT_QUERY: begin
                            if (len_reg == '0) begin
                                out_next.covered_count     = tot_reg;
                                out_next.sequence_length   = 13'(len_reg);
                                out_next.coverage_fraction = '0;
                                out_next.status = err_reg[1] ? ST_SEQ_OVF :
                                                  err_reg[0] ? ST_PEP_LONG : ST_OK;
                                ov_next = 1'b1;
                            end else begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                cov_we = 1'b1;
                cov_a  = start_reg[SA-1:0];
                start_next = start_reg + 1'b1;
                if (start_reg == SL'(MAX_SEQUENCE - 1)) begin
                    if (load_reg) begin
                        len_next = SL'(1);
                        seq_we   = 1'b1;
                        seq_wa   = '0;
                        seq_wd   = res_reg;
                    end else begin
                        len_next = '0;
                    end
                    load_next = 1'b0;
                    tot_next  = '0;
                    err_next  = '0;
                    done_next = pend_reg;
                    state_next = S_IDLE;
                end
            end
            S_CMP_ADDR: state_next = S_CMP_WAIT;
            S_CMP_WAIT: state_next = S_CMP_TEST;
            S_CMP_TEST: begin
                if (seq_rd_reg != pep_rd_reg) begin
                    j_next = '0;
                    if (start_reg + SL'(plen_reg) >= len_reg) begin
                        plen_next  = '0;
                        state_next = S_IDLE;
                    end else begin
                        start_next = start_reg + 1'b1;
                        state_next = S_CMP_ADDR;
                    end
                end else if (j_reg + 1'b1 == plen_reg) begin
                    j_next     = '0;
                    state_next = S_MARK_ADDR;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_CMP_ADDR;
                end
            end
            S_MARK_ADDR: state_next = S_MARK_WAIT;
            S_MARK_WAIT: state_next = S_MARK_TEST;
            S_MARK_TEST: begin
                if (!cov_rd_reg) begin
                    cov_we   = 1'b1;
                    cov_wd   = 1'b1;
                    tot_next = tot_reg + 1'b1;
                end
                if (j_reg + 1'b1 == plen_reg) begin
                    j_next = '0;
                    if (start_reg + SL'(plen_reg) >= len_reg) begin
                        plen_next  = '0;
                        state_next = S_IDLE;
                    end else begin
                        start_next = start_reg + 1'b1;
                        state_next = S_CMP_ADDR;
                    end
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_MARK_ADDR;
                end
            end
            S_DIV: begin
                if (div_done) state_next = S_OUT;
            end
            S_OUT: begin
                out_next.covered_count     = tot_reg;
                out_next.sequence_length   = 13'(len_reg);
                out_next.coverage_fraction = div_q;
                out_next.status = err_reg[1] ? ST_SEQ_OVF :
                                  err_reg[0] ? ST_PEP_LONG : ST_OK;
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        out_reg    <= out_next;
        j_reg      <= j_next;
        res_reg    <= res_next;
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            len_reg    <= '0;
            plen_reg   <= '0;
            tot_reg    <= '0;
            done_reg   <= 1'b0;
            err_reg    <= '0;
            polong_reg <= 1'b0;
            ov_reg     <= 1'b0;
            start_reg  <= '0;
            pend_reg   <= 1'b0;
            load_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            plen_reg   <= plen_next;
            tot_reg    <= tot_next;
            done_reg   <= done_next;
            err_reg    <= err_next;
            polong_reg <= polong_next;
            ov_reg     <= ov_next;
            start_reg  <= start_next;
            pend_reg   <= pend_next;
            load_reg   <= load_next;
        end
    end

    assign m_valid = ov_reg;
    assign m_data  = out_reg;
endmodule
